@@ src/arr_pkg.sv @@
`default_nettype none

package arr_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SCALED_W  = SAMPLE_W + 1;
	localparam int CHAN_W    = 3;
	localparam int QUANT_W   = 5;
	localparam int COUNT_W   = 4;
	localparam int COEF_W    = 8;
	localparam int NUM_COEFS = 4;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_QUANT  = 3'd1,
		REG_COUNT  = 3'd2,
		REG_COEF1  = 3'd3,
		REG_COEF2  = 3'd4,
		REG_COEF3  = 3'd5,
		REG_COEF4  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		MODE_PRED   = 1'b0,
		MODE_STEREO = 1'b1
	} mode_t;

	// one result item
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0]          chan;
		logic                       last;
	} res_t;

	// results handed to the output queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		res_t       e0;
		res_t       e1;
	} push_t;

	// residual scaled by 2^(16-q) for q of 1 to 15, else unscaled, kept to 17 bits (enough for wrap and the halving)
	function automatic logic [SCALED_W-1:0] scale17(input logic signed [31:0] r,
		input logic [QUANT_W-1:0] q);
		logic [QUANT_W-1:0] sh;
		sh = (q == '0 || q >= QUANT_W'(SAMPLE_W)) ? '0 : QUANT_W'(SAMPLE_W) - q;
		return SCALED_W'(r <<< sh);
	endfunction

endpackage

`default_nettype wire

@@ src/arr_if.sv @@
`default_nettype none

interface arr_in_if #(parameter int RESIDUAL_WIDTH = 20) ();
	logic                             valid;
	logic                             ready;
	logic signed [RESIDUAL_WIDTH-1:0] residual;

	modport source (output valid, residual, input ready);
	modport sink (input valid, residual, output ready);
endinterface

interface arr_out_if ();
	import arr_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]          chan;
	logic                       last;

	modport source (output valid, sample, chan, last, input ready);
	modport sink (input valid, sample, chan, last, output ready);
endinterface

`default_nettype wire

@@ src/audio_residual_reconstructor_unit.sv @@
// Throughput: 1 residual per cycle, both modes, while the output queue has room;
// in prediction mode one history-row read at accept and one write-back per item,
// with same-row forwarding in the history memory. Output goes through a 4-entry
// queue; input stalls when stage 1 holds an item and fewer than 2 slots are free.
// Reset (arst_n low, asynchronous): registers to defaults, channel counter, pair
// phase and queue cleared; history rows read as zero until first written.
`default_nettype none

module audio_residual_reconstructor_unit #(
	parameter int MAX_CHANNELS   = 8,
	parameter int PRED_ORDER     = 4,
	parameter int RESIDUAL_WIDTH = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [arr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [arr_pkg::CFG_W-1:0]      cfg_data,
	arr_in_if.sink                              res_in,
	arr_out_if.source                           pcm_out
);
	import arr_pkg::*;

	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ROW_W = PRED_ORDER * SAMPLE_W;
	localparam int NTAPS = (PRED_ORDER < NUM_COEFS) ? PRED_ORDER : NUM_COEFS;
	localparam int CMPW  = COUNT_W + 1;
	localparam int PW    = SAMPLE_W + COEF_W;

	// configuration registers
	mode_t                    mode_q;
	logic [QUANT_W-1:0]       quant_q;
	logic [COUNT_W-1:0]       count_q;
	logic signed [COEF_W-1:0] coef_q [NUM_COEFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PRED;
			quant_q <= '0;
			count_q <= COUNT_W'(2);
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MODE:  mode_q    <= mode_t'(cfg_data[0]);
				REG_QUANT: quant_q   <= cfg_data[QUANT_W-1:0];
				REG_COUNT: count_q   <= cfg_data[COUNT_W-1:0];
				REG_COEF1: coef_q[0] <= cfg_data;
				REG_COEF2: coef_q[1] <= cfg_data;
				REG_COEF3: coef_q[2] <= cfg_data;
				REG_COEF4: coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel selection at accept
	logic [CW-1:0]   cnt_q;
	logic [CMPW-1:0] count_eff;
	logic [CW-1:0]   ch_cur;
	logic [CW:0]     ch_inc;
	logic [CW-1:0]   ch_next;

	always_comb begin
		if (count_q == '0) begin
			count_eff = CMPW'(1);
		end else if (CMPW'(count_q) > CMPW'(MAX_CHANNELS)) begin
			count_eff = CMPW'(MAX_CHANNELS);
		end else begin
			count_eff = CMPW'(count_q);
		end
		ch_cur  = (CMPW'(cnt_q) >= count_eff) ? '0 : cnt_q;
		ch_inc  = (CW+1)'(ch_cur) + (CW+1)'(1);
		ch_next = (CMPW'(ch_inc) >= count_eff) ? '0 : ch_inc[CW-1:0];
	end

	// handshake and stage 1 control
	logic                             s1_valid_q;
	logic                             room;
	logic                             s1_go;
	logic                             accept;
	logic                             is_mid;
	logic                             phase_q;
	logic signed [RESIDUAL_WIDTH-1:0] mid_q;

	assign s1_go        = s1_valid_q && room;
	assign res_in.ready = !s1_valid_q || room;
	assign accept       = res_in.valid && res_in.ready;
	assign is_mid       = (mode_q == MODE_STEREO) && !phase_q;

	mode_t                            mode_s1;
	logic [CW-1:0]                    ch_s1;
	logic signed [RESIDUAL_WIDTH-1:0] res_s1;
	logic signed [RESIDUAL_WIDTH-1:0] mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			cnt_q      <= '0;
			phase_q    <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= !is_mid;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (accept && mode_q == MODE_PRED) begin
				cnt_q <= ch_next;
			end
			if (accept && mode_q == MODE_STEREO) begin
				phase_q <= !phase_q;
			end
		end
	end

	// payload of stage 1 and the held mid residual
	always_ff @(posedge clk) begin
		if (accept && is_mid) begin
			mid_q <= res_in.residual;
		end
		if (accept) begin
			mode_s1 <= mode_q;
			ch_s1   <= ch_cur;
			res_s1  <= res_in.residual;
			mid_s1  <= mid_q;
		end
	end

	// per-channel history rows, newest sample in the low lane
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;
	logic             hist_we;

	assign hist_we = s1_go && (mode_s1 == MODE_PRED);

	arr_hist_mem #(
		.DEPTH (MAX_CHANNELS),
		.ROW_W (ROW_W),
		.AW    (CW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && mode_q == MODE_PRED),
		.rd_addr (ch_cur),
		.wr_en   (hist_we),
		.wr_addr (ch_s1),
		.wr_data (row_wr),
		.rd_data (row_rd)
	);

	// stage 1 datapath: prediction, or mid/side to left/right
	logic [SCALED_W-1:0]            y_sc;
	logic [SCALED_W-1:0]            x_sc;
	logic [SAMPLE_W-1:0]            pred;
	logic [SAMPLE_W-1:0]            pcm;
	logic signed [PW-1:0]           prod;
	logic [ROW_W+SAMPLE_W-1:0]      row_ext;
	logic [SAMPLE_W-1:0]            right;
	logic [SAMPLE_W-1:0]            left;
	push_t                          push;

	always_comb begin
		y_sc = scale17(32'(res_s1), quant_q);
		x_sc = scale17(32'(mid_s1), quant_q);
		pred = '0;
		for (int k = 0; k < NTAPS; k++) begin
			prod = PW'(coef_q[k]) * PW'($signed(row_rd[k*SAMPLE_W +: SAMPLE_W]));
			pred = pred + prod[SAMPLE_W-1:0];
		end
		pcm     = y_sc[SAMPLE_W-1:0] + pred;
		row_ext = {row_rd, pcm};
		row_wr  = row_ext[ROW_W-1:0];
		// R = X - floor(Y/2), L = Y + R
		right   = x_sc[SAMPLE_W-1:0] - y_sc[SCALED_W-1:1];
		left    = y_sc[SAMPLE_W-1:0] + right;

		push = '0;
		if (s1_go) begin
			if (mode_s1 == MODE_PRED) begin
				push.cnt       = 2'd1;
				push.e0.sample = pcm;
				push.e0.chan   = CHAN_W'(ch_s1);
				push.e0.last   = 1'b1;
			end else begin
				push.cnt       = 2'd2;
				push.e0.sample = left;
				push.e0.chan   = CHAN_W'(0);
				push.e0.last   = 1'b0;
				push.e1.sample = right;
				push.e1.chan   = CHAN_W'(1);
				push.e1.last   = 1'b1;
			end
		end
	end

	arr_out_fifo u_oq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.pcm_out (pcm_out)
	);

endmodule

`default_nettype wire

@@ src/arr_hist_mem.sv @@
`default_nettype none

module arr_hist_mem #(
	parameter int DEPTH = 8,
	parameter int ROW_W = 64,
	parameter int AW    = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [ROW_W-1:0] wr_data,
	output logic [ROW_W-1:0]      rd_data
);
	import arr_pkg::*;

	logic [ROW_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_vld_q;
	logic [ROW_W-1:0] rd_q;
	logic             rd_vld_q;
	logic             same;

	assign same = wr_en && (wr_addr == rd_addr);

	// storage and registered read, write data forwarded on a same-row hit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= same ? wr_data : mem[rd_addr];
		end
	end

	// row valid bits: an unwritten row reads as zero history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= same | row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

@@ src/arr_out_fifo.sv @@
`default_nettype none

module arr_out_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire arr_pkg::push_t push,
	output logic               room,
	arr_out_if.source          pcm_out
);
	import arr_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	res_t            buf_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;
	logic            pop;
	logic [PW-1:0]   wp1;

	assign wp1  = wp_q + PW'(1);
	assign pop  = pcm_out.valid && pcm_out.ready;
	assign room = (cnt_q <= (PW+1)'(DEPTH - 2));

	// entries, up to two written per cycle
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			buf_q[wp_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			buf_q[wp1] <= push.e1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.cnt);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + (PW+1)'(push.cnt) - (PW+1)'(pop);
		end
	end

	assign pcm_out.valid  = (cnt_q != '0);
	assign pcm_out.sample = buf_q[rp_q].sample;
	assign pcm_out.chan   = buf_q[rp_q].chan;
	assign pcm_out.last   = buf_q[rp_q].last;

endmodule

`default_nettype wire

@@ src/arr_checker.sv @@
`default_nettype none

module arr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [arr_pkg::SAMPLE_W-1:0] out_sample,
	input wire logic [arr_pkg::CHAN_W-1:0]   out_chan,
	input wire logic                         out_last
);
	import arr_pkg::*;

	// a held item stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pcm_out valid dropped while stalled");

	// a held item keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_chan)
		&& $stable(out_last))
		else $error("pcm_out payload changed while stalled");

	// left sample is queued together with its right sample
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("right sample missing after left");

	// only the left sample of a pair is not last
	a_left_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_chan == CHAN_W'(0))
		else $error("non-last item not on channel 0");

endmodule

bind audio_residual_reconstructor_unit arr_checker u_arr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pcm_out.valid),
	.out_ready  (pcm_out.ready),
	.out_sample (pcm_out.sample),
	.out_chan   (pcm_out.chan),
	.out_last   (pcm_out.last)
);

`default_nettype wire
